FILE: sv/pic_pkg.sv
// shared types, widths and constants of the point-in-cylinder counter
// used by pic_mac, pic_ctrl and point_in_cylinder_counter; no dependencies
`default_nettype none

package pic_pkg;

	// coordinate and derived widths
	localparam int COORD_BITS = 24;
	localparam int MAX_POINTS = 1048576;
	localparam int RAD_BITS   = 23;
	localparam int CNT_BITS   = 21;
	localparam int W_DIFF     = COORD_BITS + 1;
	localparam int W_DOT      = 2 * W_DIFF + 2;
	localparam int LIMB       = W_DOT / 2;
	localparam int W_OP       = LIMB + 1;
	localparam int W_PROD     = 2 * W_OP;
	localparam int W_ACC      = 2 * W_DOT;
	localparam int CFG_BITS   = 3;

	localparam int CNT_MAX = (1 << CNT_BITS) - 1;
	localparam logic [CNT_BITS-1:0] COUNT_CAP =
		CNT_BITS'((MAX_POINTS < CNT_MAX) ? MAX_POINTS : CNT_MAX);

	// register indexes of the configuration port
	typedef enum logic [CFG_BITS-1:0] {
		REG_END_A_X      = 3'd0,
		REG_END_A_Y      = 3'd1,
		REG_END_A_Z      = 3'd2,
		REG_END_B_X      = 3'd3,
		REG_END_B_Y      = 3'd4,
		REG_END_B_Z      = 3'd5,
		REG_RADIUS       = 3'd6,
		REG_SPARSE_THR   = 3'd7
	} reg_idx_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [W_OP-1:0] opnd_t;
	typedef logic signed [W_DOT-1:0] dot_t;
	typedef logic signed [W_ACC-1:0] acc_t;

	// accumulator behavior and product alignment
	typedef enum logic [1:0] {
		MODE_LOAD,
		MODE_ADD,
		MODE_SUB
	} mode_t;

	typedef enum logic [1:0] {
		SH_0,
		SH_L,
		SH_L1,
		SH_2L
	} shift_t;

	// which partial result the accumulator holds after a product lands
	typedef enum logic [2:0] {
		TAG_NONE,
		TAG_RR,
		TAG_UU,
		TAG_DD,
		TAG_UD
	} tag_t;

	// one operation of the shared multiply-accumulate unit
	typedef struct packed {
		logic   valid;
		opnd_t  a;
		opnd_t  b;
		shift_t sh;
		mode_t  mode;
		tag_t   tag;
	} op_t;

	// finished point handed from the sequencer to the output stage
	typedef struct packed {
		logic valid;
		logic hit;
		logic last;
	} res_t;

	// low limb of a wide value, zero extended
	function automatic opnd_t lo_limb(input dot_t x);
		lo_limb = {1'b0, x[LIMB-1:0]};
	endfunction

	// high limb of a wide value, sign extended
	function automatic opnd_t hi_limb(input dot_t x);
		hi_limb = {x[W_DOT-1], x[W_DOT-1:LIMB]};
	endfunction

	// difference to operand width
	function automatic opnd_t diff_op(input logic signed [W_DIFF-1:0] x);
		diff_op = {{(W_OP-W_DIFF){x[W_DIFF-1]}}, x};
	endfunction

endpackage

`default_nettype wire

FILE: sv/pic_mac.sv
// shared signed multiplier with registered product and wide accumulator
// depends on pic_pkg for operand, accumulator and operation types
`default_nettype none

module pic_mac (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire pic_pkg::op_t  op,
	output pic_pkg::acc_t      acc,
	output pic_pkg::tag_t      tag
);

	logic signed [pic_pkg::W_PROD-1:0] prod_s1;
	logic                              vld_s1;
	pic_pkg::shift_t                   sh_s1;
	pic_pkg::mode_t                    mode_s1;
	pic_pkg::tag_t                     tag_s1;
	pic_pkg::tag_t                     tag_s2;
	pic_pkg::acc_t                     acc_q;
	pic_pkg::acc_t                     ext;
	pic_pkg::acc_t                     aligned;

	// product stage
	always_ff @(posedge clk) begin
		prod_s1 <= op.a * op.b;
		sh_s1   <= op.sh;
		mode_s1 <= op.mode;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			tag_s1 <= pic_pkg::TAG_NONE;
			tag_s2 <= pic_pkg::TAG_NONE;
		end else begin
			vld_s1 <= op.valid;
			tag_s1 <= op.valid ? op.tag : pic_pkg::TAG_NONE;
			tag_s2 <= vld_s1 ? tag_s1 : pic_pkg::TAG_NONE;
		end
	end

	// align product to its limb position
	always_comb begin
		ext = {{(pic_pkg::W_ACC-pic_pkg::W_PROD){prod_s1[pic_pkg::W_PROD-1]}}, prod_s1};
		unique case (sh_s1)
			pic_pkg::SH_0:  aligned = ext;
			pic_pkg::SH_L:  aligned = ext <<< pic_pkg::LIMB;
			pic_pkg::SH_L1: aligned = ext <<< (pic_pkg::LIMB + 1);
			pic_pkg::SH_2L: aligned = ext <<< (2 * pic_pkg::LIMB);
			default:        aligned = ext;
		endcase
	end

	// accumulate
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			unique case (mode_s1)
				pic_pkg::MODE_LOAD: acc_q <= aligned;
				pic_pkg::MODE_ADD:  acc_q <= acc_q + aligned;
				pic_pkg::MODE_SUB:  acc_q <= acc_q - aligned;
				default:            acc_q <= aligned;
			endcase
		end
	end

	assign acc = acc_q;
	assign tag = tag_s2;

endmodule

`default_nettype wire

FILE: sv/pic_ctrl.sv
// sequencer: feeds the shared multiply-accumulate unit one product per step
// and decides inside or outside; depends on pic_pkg
`default_nettype none

module pic_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire pic_pkg::coord_t pt [3],
	input  wire logic            last_point,
	input  wire pic_pkg::coord_t end_a [3],
	input  wire pic_pkg::coord_t end_b [3],
	input  wire logic [pic_pkg::RAD_BITS-1:0] radius,
	input  wire logic            fin_ok,
	input  wire pic_pkg::acc_t   acc,
	input  wire pic_pkg::tag_t   tag,
	output logic                 busy,
	output pic_pkg::op_t         op,
	output pic_pkg::res_t        res
);

	localparam logic [4:0] FINAL_STEP = 5'd18;

	typedef enum logic {
		ST_IDLE,
		ST_BUSY
	} state_t;

	state_t     state_q;
	logic [4:0] step_q;

	logic signed [pic_pkg::W_DIFF-1:0] d_q [3];
	logic signed [pic_pkg::W_DIFF-1:0] u_q [3];
	logic        last_q;
	pic_pkg::dot_t rr_q;
	pic_pkg::dot_t e_q;
	pic_pkg::dot_t dd_q;
	pic_pkg::dot_t ud_q;
	pic_pkg::opnd_t r_op;
	logic at_final;
	logic in_cyl;

	assign at_final = (state_q == ST_BUSY) && (step_q == FINAL_STEP);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_BUSY;
						step_q  <= '0;
					end
				end
				ST_BUSY: begin
					if (step_q == FINAL_STEP) begin
						if (fin_ok)
							state_q <= ST_IDLE;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// axis and offset vectors, then partial results as they land
	always_ff @(posedge clk) begin
		if (start) begin
			for (int k = 0; k < 3; k++) begin
				d_q[k] <= {end_b[k][pic_pkg::COORD_BITS-1], end_b[k]}
					- {end_a[k][pic_pkg::COORD_BITS-1], end_a[k]};
				u_q[k] <= {pt[k][pic_pkg::COORD_BITS-1], pt[k]}
					- {end_a[k][pic_pkg::COORD_BITS-1], end_a[k]};
			end
			last_q <= last_point;
		end
		unique case (tag)
			pic_pkg::TAG_RR: rr_q <= acc[pic_pkg::W_DOT-1:0];
			pic_pkg::TAG_UU: e_q  <= acc[pic_pkg::W_DOT-1:0] - rr_q;
			pic_pkg::TAG_DD: dd_q <= acc[pic_pkg::W_DOT-1:0];
			pic_pkg::TAG_UD: ud_q <= acc[pic_pkg::W_DOT-1:0];
			default: ;
		endcase
	end

	assign r_op = {{(pic_pkg::W_OP-pic_pkg::RAD_BITS){1'b0}}, radius};

	// product schedule: r^2, |u|^2 (then e = |u|^2 - r^2), |d|^2, u.d,
	// then |d|^2 * e - (u.d)^2 in limbs
	always_comb begin
		op = '0;
		op.sh   = pic_pkg::SH_0;
		op.mode = pic_pkg::MODE_ADD;
		op.tag  = pic_pkg::TAG_NONE;
		if (state_q == ST_BUSY) begin
			op.valid = 1'b1;
			unique case (step_q)
				5'd0: begin
					op.a = r_op; op.b = r_op;
					op.mode = pic_pkg::MODE_LOAD; op.tag = pic_pkg::TAG_RR;
				end
				5'd1: begin
					op.a = pic_pkg::diff_op(u_q[0]); op.b = pic_pkg::diff_op(u_q[0]);
					op.mode = pic_pkg::MODE_LOAD;
				end
				5'd2: begin
					op.a = pic_pkg::diff_op(u_q[1]); op.b = pic_pkg::diff_op(u_q[1]);
				end
				5'd3: begin
					op.a = pic_pkg::diff_op(u_q[2]); op.b = pic_pkg::diff_op(u_q[2]);
					op.tag = pic_pkg::TAG_UU;
				end
				5'd4: begin
					op.a = pic_pkg::diff_op(d_q[0]); op.b = pic_pkg::diff_op(d_q[0]);
					op.mode = pic_pkg::MODE_LOAD;
				end
				5'd5: begin
					op.a = pic_pkg::diff_op(d_q[1]); op.b = pic_pkg::diff_op(d_q[1]);
				end
				5'd6: begin
					op.a = pic_pkg::diff_op(d_q[2]); op.b = pic_pkg::diff_op(d_q[2]);
					op.tag = pic_pkg::TAG_DD;
				end
				5'd7: begin
					op.a = pic_pkg::diff_op(u_q[0]); op.b = pic_pkg::diff_op(d_q[0]);
					op.mode = pic_pkg::MODE_LOAD;
				end
				5'd8: begin
					op.a = pic_pkg::diff_op(u_q[1]); op.b = pic_pkg::diff_op(d_q[1]);
				end
				5'd9: begin
					op.a = pic_pkg::diff_op(u_q[2]); op.b = pic_pkg::diff_op(d_q[2]);
					op.tag = pic_pkg::TAG_UD;
				end
				5'd10: begin
					op.a = pic_pkg::lo_limb(dd_q); op.b = pic_pkg::lo_limb(e_q);
					op.mode = pic_pkg::MODE_LOAD;
				end
				5'd11: begin
					op.a = pic_pkg::lo_limb(dd_q); op.b = pic_pkg::hi_limb(e_q);
					op.sh = pic_pkg::SH_L;
				end
				5'd12: begin
					op.a = pic_pkg::hi_limb(dd_q); op.b = pic_pkg::lo_limb(e_q);
					op.sh = pic_pkg::SH_L;
				end
				5'd13: begin
					op.a = pic_pkg::hi_limb(dd_q); op.b = pic_pkg::hi_limb(e_q);
					op.sh = pic_pkg::SH_2L;
				end
				5'd14: begin
					op.a = pic_pkg::lo_limb(ud_q); op.b = pic_pkg::lo_limb(ud_q);
					op.mode = pic_pkg::MODE_SUB;
				end
				5'd15: begin
					op.a = pic_pkg::lo_limb(ud_q); op.b = pic_pkg::hi_limb(ud_q);
					op.mode = pic_pkg::MODE_SUB; op.sh = pic_pkg::SH_L1;
				end
				5'd16: begin
					op.a = pic_pkg::hi_limb(ud_q); op.b = pic_pkg::hi_limb(ud_q);
					op.mode = pic_pkg::MODE_SUB; op.sh = pic_pkg::SH_2L;
				end
				default: op.valid = 1'b0;
			endcase
		end
	end

	// inside: cross term within radius and projection between the end caps
	assign in_cyl = (acc[pic_pkg::W_ACC-1] || (acc == '0))
		&& !ud_q[pic_pkg::W_DOT-1] && (ud_q <= dd_q);

	assign busy       = (state_q != ST_IDLE);
	assign res.valid  = at_final && fin_ok;
	assign res.hit    = in_cyl;
	assign res.last   = last_q;

endmodule

`default_nettype wire

FILE: sv/point_in_cylinder_counter.sv
// top level of the point-in-cylinder counter: configuration registers,
// inside count and output register; depends on pic_pkg, pic_mac, pic_ctrl
//
// Usage: a point request (point_x/y/z, last_point) is taken when in_valid is
// high and in_stall low. Each point yields exactly one result request
// (inside_res, count_so_far, end_of_set, sparse) on out_valid/out_stall.
// Configuration writes (cfg_index, cfg_data) are taken on cfg_valid with
// cfg_ready, which is always high; write only while no point is in flight.
// Sequence: the 17 products go one per cycle through the shared multiplier,
// then through its product and accumulator registers, and the result is
// loaded in the output register. in_stall is high while the point is in
// flight; a new point can be taken the cycle after the result is loaded,
// while that result still waits.
// If the receiver stalls with a result still waiting, the next point holds
// in its last step until the output register frees. Reset clears the
// count and the output valid and loads the register defaults (endpoints 0,
// radius 6554, sparse threshold 5).
`default_nettype none

module point_in_cylinder_counter (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire pic_pkg::coord_t                     point_x,
	input  wire pic_pkg::coord_t                     point_y,
	input  wire pic_pkg::coord_t                     point_z,
	input  wire logic                                last_point,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     inside_res,
	output logic [pic_pkg::CNT_BITS-1:0]             count_so_far,
	output logic                                     end_of_set,
	output logic                                     sparse,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [pic_pkg::CFG_BITS-1:0]        cfg_index,
	input  wire logic [pic_pkg::COORD_BITS-1:0]      cfg_data
);

	pic_pkg::coord_t end_a_q [3];
	pic_pkg::coord_t end_b_q [3];
	pic_pkg::coord_t pt [3];
	logic [pic_pkg::RAD_BITS-1:0] radius_q;
	logic [pic_pkg::CNT_BITS-1:0] thr_q;
	logic [pic_pkg::CNT_BITS-1:0] count_q;
	logic [pic_pkg::CNT_BITS-1:0] cnt_next;

	logic                         out_valid_q;
	logic                         inside_q;
	logic [pic_pkg::CNT_BITS-1:0] count_out_q;
	logic                         eos_q;
	logic                         sparse_q;

	logic          start;
	logic          busy;
	logic          fin_ok;
	pic_pkg::op_t  op;
	pic_pkg::acc_t acc;
	pic_pkg::tag_t tag;
	pic_pkg::res_t res;

	assign cfg_ready = 1'b1;
	assign in_stall  = busy;
	assign start     = in_valid && !busy;
	assign fin_ok    = !out_valid_q || !out_stall;

	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				end_a_q[k] <= '0;
				end_b_q[k] <= '0;
			end
			radius_q <= pic_pkg::RAD_BITS'(6554);
			thr_q    <= pic_pkg::CNT_BITS'(5);
		end else if (cfg_valid && cfg_ready) begin
			unique case (pic_pkg::reg_idx_t'(cfg_index))
				pic_pkg::REG_END_A_X:    end_a_q[0] <= cfg_data;
				pic_pkg::REG_END_A_Y:    end_a_q[1] <= cfg_data;
				pic_pkg::REG_END_A_Z:    end_a_q[2] <= cfg_data;
				pic_pkg::REG_END_B_X:    end_b_q[0] <= cfg_data;
				pic_pkg::REG_END_B_Y:    end_b_q[1] <= cfg_data;
				pic_pkg::REG_END_B_Z:    end_b_q[2] <= cfg_data;
				pic_pkg::REG_RADIUS:     radius_q <= cfg_data[pic_pkg::RAD_BITS-1:0];
				pic_pkg::REG_SPARSE_THR: thr_q <= cfg_data[pic_pkg::CNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	pic_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.acc    (acc),
		.tag    (tag)
	);

	pic_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.pt         (pt),
		.last_point (last_point),
		.end_a      (end_a_q),
		.end_b      (end_b_q),
		.radius     (radius_q),
		.fin_ok     (fin_ok),
		.acc        (acc),
		.tag        (tag),
		.busy       (busy),
		.op         (op),
		.res        (res)
	);

	// saturating inside count
	assign cnt_next = (res.hit && (count_q < pic_pkg::COUNT_CAP))
		? count_q + pic_pkg::CNT_BITS'(1) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res.valid) begin
				count_q     <= res.last ? '0 : cnt_next;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (res.valid) begin
			inside_q    <= res.hit;
			count_out_q <= cnt_next;
			eos_q       <= res.last;
			sparse_q    <= res.last && (cnt_next < thr_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign inside_res   = inside_q;
	assign count_so_far = count_out_q;
	assign end_of_set   = eos_q;
	assign sparse       = sparse_q;

	// a taken point keeps the block busy on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("point taken while block already idle next cycle");

	// count never passes its cap
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> count_so_far <= pic_pkg::COUNT_CAP)
		else $error("inside count beyond cap");

	// sparse only closes a set
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_of_set |-> !sparse)
		else $error("sparse flagged outside set end");

	// a new result is only loaded when the output register is free
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !out_valid || !out_stall)
		else $error("result overwrote a stalled output");

endmodule

`default_nettype wire
